// ----- hdl/hal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_pkg
// Shared constants and types for the histogram auto-levels block.
// ----------------------------------------------------------------------------
package hal_pkg;

  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 32;
  localparam int IDX_W      = $clog2(NUM_BINS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TOT_W      = COUNT_BITS + IDX_W;
  localparam int PROD_W     = TOT_W + 12;
  localparam int LEVEL_W    = 8;
  localparam int CHAN_W     = 3;

  typedef logic [TOT_W-1:0]         total_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_START = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_CAP   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_CMP   = 7'b1000000
  } state_t;

endpackage

// ----- hdl/histogram_auto_levels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_auto_levels
// Auto-levels input range finder for one histogram channel (0.6 % clip).
// ----------------------------------------------------------------------------
// Bins are loaded one per cycle with start while busy is low; the bin that
// carries last_bin ends the histogram. Bins beyond NUM_BINS are dropped, and
// missing bins count as zero. After the last bin the block is busy: it checks
// the total in S_START, then runs an upward and a downward scan, each primed
// by S_INIT and S_CAP, then S_RD, S_MUL and S_CMP per bin (one bin-store read
// and two passes through the shared scale-and-subtract unit per bin), up to
// NUM_BINS - 1 bins per scan. The result appears for one cycle with done high
// and must be taken then; busy falls in that same cycle.
// ----------------------------------------------------------------------------
module histogram_auto_levels (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [31:0]                  bin_count,
  input  logic [2:0]                   channel_tag,
  input  logic                         last_bin,
  output logic                         done,
  output logic [2:0]                   channel_out,
  output logic [7:0]                   low_level,
  output logic                         low_found,
  output logic [7:0]                   high_level,
  output logic                         high_found,
  output logic                         empty_histogram
);
  import hal_pkg::*;

  state_t                 state;
  total_t                 total;
  logic [CNT_W-1:0]       load_cnt;
  logic [CHAN_W-1:0]      chan;
  logic                   up;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       nidx;
  logic [IDX_W-1:0]       raddr;
  logic [COUNT_BITS-1:0]  rdata;
  logic [COUNT_BITS-1:0]  rdata_gated;
  logic [COUNT_BITS-1:0]  cur;
  logic [COUNT_BITS-1:0]  nxt;
  total_t                 csum;
  prod_t                  a;
  prod_t                  target;
  total_t                 unit_x;
  prod_t                  unit_y;
  prod_t                  unit_r;
  logic                   load_we;
  logic                   stop;
  logic                   scan_end;
  logic [IDX_W-1:0]       start_idx;
  logic [IDX_W-1:0]       raddr_q;

  assign busy    = (state != S_LOAD);
  assign load_we = start && !busy && (load_cnt < CNT_W'(NUM_BINS));

  hal_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_cnt[IDX_W-1:0]),
    .wdata (bin_count[COUNT_BITS-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  hal_scale_unit u_scale (
    .x (unit_x),
    .y (unit_y),
    .r (unit_r)
  );

  always_comb begin
    nidx      = up ? idx + IDX_W'(1) : idx - IDX_W'(1);
    start_idx = up ? '0 : IDX_W'(NUM_BINS - 1);
    raddr     = (state == S_INIT) ? start_idx : nidx;
    rdata_gated = (CNT_W'(raddr_q) < load_cnt) ? rdata : '0;
    target    = signed'(PROD_W'(total) <<< 2) + signed'(PROD_W'(total) <<< 1);
    if (state == S_CMP) begin
      unit_x = TOT_W'(nxt);
      unit_y = -(a <<< 1);
    end else begin
      unit_x = csum;
      unit_y = target;
    end
    // |1000c - 6T| < |1000(c + n) - 6T|
    stop     = (a >= 0) ? (nxt != '0) : (unit_r > 0);
    scan_end = up ? (idx == IDX_W'(NUM_BINS - 2)) : (idx == IDX_W'(1));
  end

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      total           <= '0;
      load_cnt        <= '0;
      chan            <= '0;
      up              <= 1'b1;
      idx             <= '0;
      done            <= 1'b0;
      channel_out     <= '0;
      low_level       <= '0;
      low_found       <= 1'b0;
      high_level      <= '0;
      high_found      <= 1'b0;
      empty_histogram <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          done <= 1'b0;
          if (start) begin
            if (load_cnt == '0) begin
              chan <= channel_tag;
            end
            if (load_we) begin
              total    <= total + TOT_W'(bin_count[COUNT_BITS-1:0]);
              load_cnt <= load_cnt + CNT_W'(1);
            end
            if (last_bin) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          low_level  <= '0;
          low_found  <= 1'b0;
          high_level <= '0;
          high_found <= 1'b0;
          if (total == '0) begin
            done            <= 1'b1;
            channel_out     <= chan;
            empty_histogram <= 1'b1;
            total           <= '0;
            load_cnt        <= '0;
            state           <= S_LOAD;
          end else begin
            up    <= 1'b1;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          idx   <= start_idx;
          csum  <= '0;
          state <= S_CAP;
        end
        S_CAP: begin
          cur   <= rdata_gated;
          state <= S_RD;
        end
        S_RD: begin
          csum  <= csum + TOT_W'(cur);
          state <= S_MUL;
        end
        S_MUL: begin
          a     <= unit_r;
          nxt   <= rdata_gated;
          state <= S_CMP;
        end
        S_CMP: begin
          if (stop || scan_end) begin
            if (up) begin
              low_level <= stop ? LEVEL_W'(nidx) : '0;
              low_found <= stop;
              up    <= 1'b0;
              state <= S_INIT;
            end else begin
              high_level <= stop ? LEVEL_W'(nidx) : '0;
              high_found <= stop;
              done            <= 1'b1;
              channel_out     <= chan;
              empty_histogram <= 1'b0;
              total           <= '0;
              load_cnt        <= '0;
              state           <= S_LOAD;
            end
          end else begin
            idx   <= nidx;
            cur   <= nxt;
            state <= S_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- hdl/hal_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/hal_scale_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_scale_unit
// Shared arithmetic unit: r = 1000 * x - y, built from shifts and adds.
// ----------------------------------------------------------------------------
module hal_scale_unit (
  input  hal_pkg::total_t x,
  input  hal_pkg::prod_t  y,
  output hal_pkg::prod_t  r
);
  import hal_pkg::*;

  prod_t xe;

  // 1000 = 1024 - 16 - 8
  always_comb begin
    xe = signed'(PROD_W'(x));
    r  = (xe <<< 10) - (xe <<< 4) - (xe <<< 3) - y;
  end

endmodule

// ----- verif/histogram_auto_levels_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_auto_levels_test
// Self-checking bench for the auto-levels range finder. Histograms are
// streamed bin by bin under bursty pacing. A behavioral predictor works out
// the low and high levels for each histogram with an exact integer form of
// the 0.6 % clip test. Every result is compared field by field in order.
// ----------------------------------------------------------------------------
module histogram_auto_levels_test;
  import hal_pkg::*;

  localparam int ITEM_GOAL     = 1250;
  localparam int CLIP_PERMILLE = 6;
  localparam int PERMILLE      = 1000;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] low_level;
    logic               low_found;
    logic [LEVEL_W-1:0] high_level;
    logic               high_found;
    logic               empty;
  } levels_t;

  typedef enum int {SHAPE_WIDE, SHAPE_TAILS, SHAPE_SPARSE, SHAPE_TINY, SHAPE_RAIL} shape_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        bin_count = '0;
  logic [CHAN_W-1:0]  channel_tag = '0;
  logic               last_bin = 1'b0;
  logic               done;
  logic [CHAN_W-1:0]  channel_out;
  logic [LEVEL_W-1:0] low_level;
  logic               low_found;
  logic [LEVEL_W-1:0] high_level;
  logic               high_found;
  logic               empty_histogram;

  histogram_auto_levels uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .bin_count       (bin_count),
    .channel_tag     (channel_tag),
    .last_bin        (last_bin),
    .done            (done),
    .channel_out     (channel_out),
    .low_level       (low_level),
    .low_found       (low_found),
    .high_level      (high_level),
    .high_found      (high_found),
    .empty_histogram (empty_histogram)
  );

  // predictor state
  logic [31:0]       hist_bins [NUM_BINS];
  longint unsigned   hist_total = 0;
  int                hist_fill = 0;
  logic [CHAN_W-1:0] hist_channel = '0;
  levels_t           expected_levels [$];

  int errors = 0;
  int bins_sent = 0;
  int histograms_checked = 0;
  int empty_seen = 0;
  int low_missed = 0;
  int high_missed = 0;
  int burst_left = 0;
  bit steady = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint unsigned count_at(int i);
    return (i < hist_fill) ? hist_bins[i] : 0;
  endfunction

  function automatic longint unsigned clip_distance(longint unsigned c, longint unsigned goal);
    longint unsigned scaled;
    scaled = c * PERMILLE;
    return (scaled > goal) ? scaled - goal : goal - scaled;
  endfunction

  function automatic bit scan_halts(longint unsigned c, longint unsigned nxt,
                                    longint unsigned goal);
    return clip_distance(c, goal) < clip_distance(c + nxt, goal);
  endfunction

  function automatic void predict_levels(logic [31:0] cnt, logic [CHAN_W-1:0] tag,
                                         logic last);
    levels_t r;
    longint unsigned goal;
    longint unsigned c;
    if (hist_fill == 0) hist_channel = tag;
    if (hist_fill < NUM_BINS) begin
      hist_bins[hist_fill] = cnt;
      hist_total += cnt;
      hist_fill++;
    end
    if (!last) return;
    r = '0;
    r.channel = hist_channel;
    r.empty = (hist_total == 0);
    if (!r.empty) begin
      goal = hist_total * CLIP_PERMILLE;
      c = 0;
      for (int i = 0; i < NUM_BINS - 1; i++) begin
        c += count_at(i);
        if (scan_halts(c, count_at(i + 1), goal)) begin
          r.low_level = LEVEL_W'(i + 1);
          r.low_found = 1'b1;
          break;
        end
      end
      c = 0;
      for (int i = NUM_BINS - 1; i > 0; i--) begin
        c += count_at(i);
        if (scan_halts(c, count_at(i - 1), goal)) begin
          r.high_level = LEVEL_W'(i - 1);
          r.high_found = 1'b1;
          break;
        end
      end
    end
    expected_levels.push_back(r);
    hist_total = 0;
    hist_fill = 0;
  endfunction

  // result checker: done is a one-cycle strobe that cannot be held off
  always @(posedge clk) begin
    levels_t want;
    if (!rst && done) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result transaction: channel_out %0d", channel_out);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        histograms_checked++;
        if (empty_histogram) empty_seen++;
        if (!low_found) low_missed++;
        if (!high_found) high_missed++;
        if (channel_out !== want.channel) begin
          $error("channel_out: expected %0d, got %0d", want.channel, channel_out);
          errors++;
        end
        if (low_level !== want.low_level) begin
          $error("low_level: expected %0d, got %0d", want.low_level, low_level);
          errors++;
        end
        if (low_found !== want.low_found) begin
          $error("low_found: expected %0d, got %0d", want.low_found, low_found);
          errors++;
        end
        if (high_level !== want.high_level) begin
          $error("high_level: expected %0d, got %0d", want.high_level, high_level);
          errors++;
        end
        if (high_found !== want.high_found) begin
          $error("high_found: expected %0d, got %0d", want.high_found, high_found);
          errors++;
        end
        if (empty_histogram !== want.empty) begin
          $error("empty_histogram: expected %0d, got %0d", want.empty, empty_histogram);
          errors++;
        end
      end
    end
  end

  // one bin per transaction; start stays high across back-to-back bins
  task automatic send_bin(logic [31:0] cnt, logic [CHAN_W-1:0] tag, logic last);
    start       <= 1'b1;
    bin_count   <= cnt;
    channel_tag <= tag;
    last_bin    <= last;
    do @(posedge clk); while (busy);
    predict_levels(cnt, tag, last);
    bins_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (!steady) begin
        start <= 1'b0;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 300)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_levels();
    start <= 1'b0;
    do @(posedge clk); while (expected_levels.size() != 0);
  endtask

  function automatic logic [31:0] shaped_bin(shape_t shape, int k, int n);
    case (shape)
      SHAPE_WIDE:   return $urandom;
      SHAPE_TAILS: begin
        if (k < 3 || k >= n - 3) return $urandom_range(0, 20);
        return $urandom_range(2000, 60000);
      end
      SHAPE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      SHAPE_TINY:   return $urandom_range(0, 3);
      default:      return ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  task automatic test_empty_histogram();
    send_bin(32'd0, 3'd0, 1'b0);
    send_bin(32'd0, 3'd0, 1'b0);
    send_bin(32'd0, 3'd0, 1'b1);
    send_bin(32'd0, 3'd4, 1'b1);
  endtask

  // all mass in bin 0: the upward scan never stops
  task automatic test_single_full_scale_bin();
    send_bin(32'hFFFF_FFFF, 3'd4, 1'b1);
  endtask

  // channel comes from the first bin only
  task automatic test_channel_latch_extremes();
    send_bin(32'hFFFF_FFFF, 3'd3, 1'b0);
    send_bin(32'd0, 3'd1, 1'b0);
    send_bin(32'hFFFF_FFFF, 3'd2, 1'b0);
    send_bin(32'd1, 3'd0, 1'b1);
  endtask

  task automatic test_peak_at_end();
    send_bin(32'd0, 3'd2, 1'b0);
    send_bin(32'd0, 3'd2, 1'b0);
    send_bin(32'd0, 3'd2, 1'b0);
    send_bin(32'hFFFF_FFFF, 3'd2, 1'b1);
  endtask

  task automatic test_percentile_tails();
    send_bin(32'd1, 3'd1, 1'b0);
    send_bin(32'd2, 3'd1, 1'b0);
    send_bin(32'd0, 3'd1, 1'b0);
    send_bin(32'd500, 3'd1, 1'b0);
    send_bin(32'd1000, 3'd1, 1'b0);
    send_bin(32'd1000, 3'd1, 1'b0);
    send_bin(32'd500, 3'd1, 1'b0);
    send_bin(32'd3, 3'd1, 1'b1);
  endtask

  task automatic test_full_histogram();
    logic [CHAN_W-1:0] chan;
    chan = CHAN_W'($urandom_range(0, 4));
    for (int k = 0; k < NUM_BINS; k++)
      send_bin(shaped_bin(SHAPE_TAILS, k, NUM_BINS), chan, k == NUM_BINS - 1);
  endtask

  // mass in the top bin only, so the downward scan never stops; extra bins dropped
  task automatic test_too_many_bins();
    for (int k = 0; k < NUM_BINS + 4; k++) begin
      if (k == NUM_BINS - 1) send_bin(32'h8000_0001, 3'd4, 1'b0);
      else if (k < NUM_BINS) send_bin(32'd0, 3'd4, 1'b0);
      else send_bin($urandom | 32'd1, CHAN_W'($urandom_range(0, 4)), k == NUM_BINS + 3);
    end
  endtask

  task automatic test_random_histograms(int item_goal);
    int n;
    shape_t shape;
    logic [CHAN_W-1:0] chan;
    while (bins_sent < item_goal) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      shape = shape_t'($urandom_range(0, 4));
      chan = CHAN_W'($urandom_range(0, 4));
      for (int k = 0; k < n; k++)
        send_bin(shaped_bin(shape, k, n), (k == 0) ? chan : 3'($urandom_range(0, 4)),
                 k == n - 1);
      if ($urandom_range(0, 15) == 0) wait_all_levels();
      if ($urandom_range(0, 7) == 0) steady = !steady;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_histogram();
    test_single_full_scale_bin();
    test_channel_latch_extremes();
    test_peak_at_end();
    test_percentile_tails();
    wait_all_levels();
    test_full_histogram();
    test_too_many_bins();
    test_random_histograms(ITEM_GOAL);
    wait_all_levels();
    repeat (6 * NUM_BINS + 16) @(posedge clk);
    $display("%0d bins sent, %0d histograms checked", bins_sent, histograms_checked);
    $display("%0d empty, %0d without low level, %0d without high level",
             empty_seen, low_missed, high_missed);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/hal_pkg.sv
hdl/hal_ram.sv
hdl/hal_scale_unit.sv
hdl/histogram_auto_levels.sv
verif/histogram_auto_levels_test.sv
